>>> design/hcbd_pkg.sv
// Shared constants, types and helper functions for the chunked body decoder.
// Depends on nothing; imported by http_chunked_body_decoder.
package hcbd_pkg;

   // error codes on the result channel
   localparam logic [1:0] ERR_NONE          = 2'd0;
   localparam logic [1:0] ERR_SIZE_CORRUPT  = 2'd1;
   localparam logic [1:0] ERR_SIZE_OVERFLOW = 2'd2;
   localparam logic [1:0] ERR_CHUNK_END     = 2'd3;

   // characters the parser looks for
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   // extension matcher positions: 0 seek ';', 1..18 name chars matched plus one
   localparam int unsigned        EXT_NAME_LEN = 18;
   localparam logic [4:0] MATCH_SEEK      = 5'd0;
   localparam logic [4:0] MATCH_NAME_1ST  = 5'd1;
   localparam logic [4:0] MATCH_NAME_LAST = 5'd18;
   localparam logic [4:0] MATCH_NAME_FULL = 5'd19;
   localparam logic [4:0] MATCH_DIGITS    = 5'd20;
   localparam logic [4:0] MATCH_SKIP      = 5'd21;
   localparam logic [4:0] MATCH_STOP      = 5'd22;

   localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;

   // result of the quote-aware line scanner
   typedef struct packed {
      logic ends;
      logic quoted;
      logic slashed;
   } line_scan_type;

   // hex digit decode: bit 4 flags a digit
   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type r;
      r.ok  = 1'b1;
      r.val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.val = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r.val = c[3:0] + 4'd9;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   // "use-original-body=" one character per index
   function automatic logic [7:0] ext_name_char(input logic [4:0] idx);
      logic [7:0] ch;
      case (idx)
         5'd0:  ch = 8'h75; // u
         5'd1:  ch = 8'h73; // s
         5'd2:  ch = 8'h65; // e
         5'd3:  ch = 8'h2D; // -
         5'd4:  ch = 8'h6F; // o
         5'd5:  ch = 8'h72; // r
         5'd6:  ch = 8'h69; // i
         5'd7:  ch = 8'h67; // g
         5'd8:  ch = 8'h69; // i
         5'd9:  ch = 8'h6E; // n
         5'd10: ch = 8'h61; // a
         5'd11: ch = 8'h6C; // l
         5'd12: ch = 8'h2D; // -
         5'd13: ch = 8'h62; // b
         5'd14: ch = 8'h6F; // o
         5'd15: ch = 8'h64; // d
         5'd16: ch = 8'h79; // y
         5'd17: ch = 8'h3D; // =
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // quote and escape tracking; ends is set for an LF outside quotes
   function automatic line_scan_type line_scan(input logic [7:0] c,
                                               input logic       quoted,
                                               input logic       slashed);
      line_scan_type r;
      r.ends    = 1'b0;
      r.quoted  = quoted;
      r.slashed = slashed;
      if (slashed) begin
         r.slashed = 1'b0;
      end else if (quoted) begin
         if (c == CHAR_BSLASH) begin
            r.slashed = 1'b1;
         end else if (c == CHAR_QUOTE) begin
            r.quoted = 1'b0;
         end
      end else if (c == CHAR_QUOTE) begin
         r.quoted = 1'b1;
      end else begin
         r.ends = (c == CHAR_LF);
      end
      return r;
   endfunction

endpackage

>>> design/http_chunked_body_decoder.sv
// HTTP/1.1 chunked body decoder, top level.
// Depends on hcbd_pkg for character constants, error codes and scanner helpers.

// One raw byte of a chunked message is taken per item and exactly one result
// item comes out for it, in the cycle after acceptance. A new item can be taken
// every cycle: the whole per-byte parser update (hex size shift, body count
// decrement, extension matcher, line scanner) is a single combinational pass
// from the parser state registers into the result register, and req_ready
// stays high whenever the result register is empty or being drained, so the
// sustained rate is one item per cycle. Errors are reported on the faulty
// byte; after an error or the end of the message all bytes give empty results
// until an item with new_message set restarts the parser.
module http_chunked_body_decoder #(
   parameter int unsigned SIZE_BITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_new_message,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_body_valid,
   output logic [7:0]         rsp_body_byte,
   output logic               rsp_message_done,
   output logic [1:0]         rsp_error_code,
   output logic signed [31:0] rsp_original_body_flag
);
   import hcbd_pkg::*;

   typedef enum logic [2:0] {
      PH_SIZE, PH_EXT_SKIP, PH_BODY, PH_END, PH_LAST_EXT, PH_TRAILER, PH_DONE, PH_FAILED
   } phase_type;

   // parser state
   phase_type              phase_ff,     phase_in;
   logic [SIZE_BITS-1:0]   bytes_left_ff, bytes_left_in;
   logic                   digits_ff,    digits_in;
   logic                   quoted_ff,    quoted_in;
   logic                   slashed_ff,   slashed_in;
   logic                   has_text_ff,  has_text_in;
   logic [4:0]             match_ff,     match_in;
   logic [31:0]            ext_value_ff, ext_value_in;

   // result register
   logic                   rsp_valid_ff;
   logic                   body_valid_ff, body_valid_in;
   logic [7:0]             body_byte_ff,  body_byte_in;
   logic                   done_ff,       done_in;
   logic [1:0]             error_ff,      error_in;

   logic                   accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // per-byte parser update
   always_comb begin
      phase_type            ph;
      phase_type            run_ph;
      logic                 run;
      hex_digit_type        hd;
      line_scan_type        ls;
      logic [7:0]           c;
      logic [30:0]          base;
      logic [34:0]          acc;
      logic [SIZE_BITS-1:0] bl_dec;

      c = req_data_byte;

      // a restart request clears state ahead of this byte
      if (req_new_message) begin
         ph            = PH_SIZE;
         bytes_left_in = '0;
         digits_in     = 1'b0;
         quoted_in     = 1'b0;
         slashed_in    = 1'b0;
         has_text_in   = 1'b0;
         match_in      = MATCH_SEEK;
         ext_value_in  = '1;
      end else begin
         ph            = phase_ff;
         bytes_left_in = bytes_left_ff;
         digits_in     = digits_ff;
         quoted_in     = quoted_ff;
         slashed_in    = slashed_ff;
         has_text_in   = has_text_ff;
         match_in      = match_ff;
         ext_value_in  = ext_value_ff;
      end
      phase_in      = ph;
      body_valid_in = 1'b0;
      body_byte_in  = 8'd0;
      done_in       = 1'b0;
      error_in      = ERR_NONE;

      hd     = hex_decode(c);
      ls     = line_scan(c, quoted_in, slashed_in);
      run    = 1'b0;
      run_ph = ph;
      bl_dec = bytes_left_in - {{(SIZE_BITS-1){1'b0}}, 1'b1};

      // size line: hex digits accumulate, first other byte falls through (an error if no digit came)
      if (ph == PH_SIZE) begin
         if (hd.ok) begin
            if (bytes_left_in[SIZE_BITS-2 -: 4] != 4'd0) begin
               error_in = ERR_SIZE_OVERFLOW;
               phase_in = PH_FAILED;
            end else begin
               bytes_left_in = {bytes_left_in[SIZE_BITS-5:0], hd.val};
               digits_in     = 1'b1;
            end
         end else if (!digits_in) begin
            error_in = ERR_SIZE_CORRUPT;
            phase_in = PH_FAILED;
         end else begin
            quoted_in  = 1'b0;
            slashed_in = 1'b0;
            match_in   = MATCH_SEEK;
            ls         = line_scan(c, 1'b0, 1'b0);
            run        = 1'b1;
            run_ph     = (bytes_left_in != '0) ? PH_EXT_SKIP : PH_LAST_EXT;
            phase_in   = run_ph;
         end
      end else begin
         run = 1'b1;
      end

      // decimal accumulate for the extension value, saturating
      base = (match_in == MATCH_DIGITS) ? ext_value_in[30:0] : 31'd0;
      acc  = {1'b0, base, 3'b000} + {3'b000, base, 1'b0}
           + {31'd0, c[3:0] - CHAR_ZERO[3:0]};

      if (run) begin
         unique case (run_ph)
            PH_EXT_SKIP: begin
               quoted_in  = ls.quoted;
               slashed_in = ls.slashed;
               if (ls.ends) begin
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               body_valid_in = 1'b1;
               body_byte_in  = c;
               bytes_left_in = bl_dec;
               if (bl_dec == '0) begin
                  phase_in = PH_END;
               end
            end
            PH_END: begin
               if (c == CHAR_LF) begin
                  phase_in      = PH_SIZE;
                  bytes_left_in = '0;
                  digits_in     = 1'b0;
               end else if (c != CHAR_CR) begin
                  error_in = ERR_CHUNK_END;
                  phase_in = PH_FAILED;
               end
            end
            PH_LAST_EXT: begin
               quoted_in  = ls.quoted;
               slashed_in = ls.slashed;
               if (ls.ends) begin
                  has_text_in = 1'b0;
                  phase_in    = PH_TRAILER;
               end else begin
                  // extension name matcher
                  if (match_in == MATCH_SEEK) begin
                     if (c != CHAR_SPACE && c != CHAR_TAB) begin
                        match_in = (c == CHAR_SEMI) ? MATCH_NAME_1ST : MATCH_STOP;
                     end
                  end else if (match_in >= MATCH_NAME_1ST && match_in <= MATCH_NAME_LAST) begin
                     if (!(match_in == MATCH_NAME_1ST && (c == CHAR_SPACE || c == CHAR_TAB)))
                     begin
                        if (c == ext_name_char(match_in - 5'd1)) begin
                           match_in = match_in + 5'd1;
                        end else begin
                           match_in = (c == CHAR_SEMI) ? MATCH_NAME_1ST : MATCH_SKIP;
                        end
                     end
                  end else if (match_in == MATCH_NAME_FULL || match_in == MATCH_DIGITS) begin
                     if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                        ext_value_in = (acc[34:31] != 4'd0) ? VAL_MAX : {1'b0, acc[30:0]};
                        match_in     = MATCH_DIGITS;
                     end else begin
                        match_in = MATCH_STOP;
                     end
                  end else if (match_in == MATCH_SKIP) begin
                     if (c == CHAR_SEMI) begin
                        match_in = MATCH_NAME_1ST;
                     end
                  end
               end
            end
            PH_TRAILER: begin
               quoted_in  = ls.quoted;
               slashed_in = ls.slashed;
               if (ls.ends) begin
                  if (!has_text_in) begin
                     done_in  = 1'b1;
                     phase_in = PH_DONE;
                  end
                  has_text_in = 1'b0;
               end else if (c != CHAR_CR) begin
                  has_text_in = 1'b1;
               end
            end
            default: begin
               // done or failed: byte is ignored
            end
         endcase
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIZE;
         bytes_left_ff <= '0;
         digits_ff     <= 1'b0;
         quoted_ff     <= 1'b0;
         slashed_ff    <= 1'b0;
         has_text_ff   <= 1'b0;
         match_ff      <= MATCH_SEEK;
         ext_value_ff  <= '1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            bytes_left_ff <= bytes_left_in;
            digits_ff     <= digits_in;
            quoted_ff     <= quoted_in;
            slashed_ff    <= slashed_in;
            has_text_ff   <= has_text_in;
            match_ff      <= match_in;
            ext_value_ff  <= ext_value_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, loaded with each accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         body_valid_ff <= body_valid_in;
         body_byte_ff  <= body_byte_in;
         done_ff       <= done_in;
         error_ff      <= error_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_body_valid         = body_valid_ff;
   assign rsp_body_byte          = body_byte_ff;
   assign rsp_message_done       = done_ff;
   assign rsp_error_code         = error_ff;
   assign rsp_original_body_flag = $signed(ext_value_ff);

endmodule

>>> bench/http_chunked_body_decoder_test.sv
// Testbench for http_chunked_body_decoder: chunked messages go in a byte per item,
// and each result item is checked against a parser model kept in a scoreboard class.
// Depends on hcbd_pkg and the http_chunked_body_decoder RTL.
`timescale 1ns / 1ps

module http_chunked_body_decoder_test;
   import hcbd_pkg::*;

   localparam int unsigned SIZE_BITS   = 64;
   localparam logic [63:0] SIZE_LIMIT  = (64'd1 << (SIZE_BITS - 1)) - 64'd1;
   // extension name, first character in the top byte
   localparam logic [8*EXT_NAME_LEN-1:0] EXT_NAME = "use-original-body=";
   localparam int RX_HOLD_CYCLES = 150;
   localparam int ITEM_TARGET    = 1250;   // directed part plus the random part
   localparam int REPORT_LIMIT   = 10;

   typedef enum logic [3:0] {
      PH_SIZE, PH_EXT_SKIP, PH_BODY, PH_END, PH_LAST_EXT, PH_TRAILER, PH_DONE, PH_FAILED
   } parse_phase_type;

   typedef struct packed {
      logic               body_valid;
      logic [7:0]         body_byte;
      logic               message_done;
      logic [1:0]         error_code;
      logic signed [31:0] original_body_flag;
   } decoded_item_type;

   // Parser model plus the queue of decoded items still owed by the block
   class decode_tracker;
      parse_phase_type  phase;
      logic [63:0]      bytes_left;
      bit               digits_seen, quoted, slashed, line_text;
      logic [4:0]       match_pos;
      logic [31:0]      ext_value;
      decoded_item_type pending[$];
      int               taken_items;
      int               failures;

      function new();
         restart();
         taken_items = 0;
         failures    = 0;
      endfunction

      function void restart();
         phase       = PH_SIZE;
         bytes_left  = '0;
         digits_seen = 1'b0;
         quoted      = 1'b0;
         slashed     = 1'b0;
         line_text   = 1'b0;
         match_pos   = MATCH_SEEK;
         ext_value   = '1;
      endfunction

      function int hex_value(logic [7:0] c);
         if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
         if (c >= "a" && c <= "f") return int'(c - "a") + 10;
         if (c >= "A" && c <= "F") return int'(c - "A") + 10;
         return -1;
      endfunction

      // quote and escape aware; true for an LF that closes the line
      function bit scan_line_end(logic [7:0] c);
         if (slashed) begin
            slashed = 1'b0;
            return 1'b0;
         end
         if (quoted) begin
            if (c == CHAR_BSLASH) slashed = 1'b1;
            else if (c == CHAR_QUOTE) quoted = 1'b0;
            return 1'b0;
         end
         if (c == CHAR_QUOTE) begin
            quoted = 1'b1;
            return 1'b0;
         end
         return c == CHAR_LF;
      endfunction

      // use-original-body matcher on the last-chunk extensions
      function void track_extension(logic [7:0] c);
         logic [63:0] v;
         bit          blank;
         blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
         if (match_pos == MATCH_SEEK) begin
            if (!blank) match_pos = (c == CHAR_SEMI) ? MATCH_NAME_1ST : MATCH_STOP;
         end else if (match_pos >= MATCH_NAME_1ST && match_pos <= MATCH_NAME_LAST) begin
            if (!(match_pos == MATCH_NAME_1ST && blank)) begin
               if (c == EXT_NAME[8*(EXT_NAME_LEN - match_pos) +: 8])
                  match_pos = match_pos + 5'd1;
               else match_pos = (c == CHAR_SEMI) ? MATCH_NAME_1ST : MATCH_SKIP;
            end
         end else if (match_pos == MATCH_NAME_FULL || match_pos == MATCH_DIGITS) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
               v = (match_pos == MATCH_NAME_FULL) ? 64'd0 : {32'd0, ext_value};
               v = v * 64'd10 + {56'd0, c - CHAR_ZERO};
               ext_value = (v > {32'd0, VAL_MAX}) ? VAL_MAX : v[31:0];
               match_pos = MATCH_DIGITS;
            end else begin
               match_pos = MATCH_STOP;
            end
         end else if (match_pos == MATCH_SKIP) begin
            if (c == CHAR_SEMI) match_pos = MATCH_NAME_1ST;
         end
      endfunction

      // accepted input item: advance the model and queue what the block owes
      function void take_byte(logic [7:0] c, logic fresh);
         decoded_item_type e;
         int               digit;
         bit               settled;
         e       = '0;
         settled = 1'b0;
         taken_items++;
         if (fresh) restart();
         if (phase == PH_SIZE) begin
            digit   = hex_value(c);
            settled = 1'b1;
            if (digit >= 0) begin
               if (bytes_left > ((SIZE_LIMIT - 64'(digit)) >> 4)) begin
                  e.error_code = ERR_SIZE_OVERFLOW;
                  phase        = PH_FAILED;
               end else begin
                  bytes_left  = (bytes_left << 4) | 64'(digit);
                  digits_seen = 1'b1;
               end
            end else if (!digits_seen) begin
               e.error_code = ERR_SIZE_CORRUPT;
               phase        = PH_FAILED;
            end else begin
               // size ended: this byte opens the extension part
               settled   = 1'b0;
               quoted    = 1'b0;
               slashed   = 1'b0;
               match_pos = MATCH_SEEK;
               phase     = (bytes_left != 0) ? PH_EXT_SKIP : PH_LAST_EXT;
            end
         end
         if (!settled) begin
            case (phase)
               PH_EXT_SKIP: begin
                  if (scan_line_end(c)) begin
                     quoted  = 1'b0;
                     slashed = 1'b0;
                     phase   = PH_BODY;
                  end
               end
               PH_BODY: begin
                  e.body_valid = 1'b1;
                  e.body_byte  = c;
                  bytes_left   = bytes_left - 64'd1;
                  if (bytes_left == 0) phase = PH_END;
               end
               PH_END: begin
                  if (c == CHAR_LF) begin
                     phase       = PH_SIZE;
                     bytes_left  = '0;
                     digits_seen = 1'b0;
                  end else if (c != CHAR_CR) begin
                     e.error_code = ERR_CHUNK_END;
                     phase        = PH_FAILED;
                  end
               end
               PH_LAST_EXT: begin
                  if (scan_line_end(c)) begin
                     quoted    = 1'b0;
                     slashed   = 1'b0;
                     line_text = 1'b0;
                     phase     = PH_TRAILER;
                  end else begin
                     track_extension(c);
                  end
               end
               PH_TRAILER: begin
                  if (scan_line_end(c)) begin
                     quoted  = 1'b0;
                     slashed = 1'b0;
                     if (!line_text) begin
                        e.message_done = 1'b1;
                        phase          = PH_DONE;
                     end
                     line_text = 1'b0;
                  end else if (c != CHAR_CR) begin
                     line_text = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         e.original_body_flag = ext_value;
         pending.push_back(e);
      endfunction

      function string describe(decoded_item_type r);
         return $sformatf("body_valid=%0b body_byte=%02h done=%0b error=%0d flag=%0d",
                          r.body_valid, r.body_byte, r.message_done, r.error_code,
                          r.original_body_flag);
      endfunction

      // result item from the block against the oldest owed item
      function void compare_result(decoded_item_type got);
         decoded_item_type want;
         if (pending.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: result with nothing owed: %s", $time, describe(got));
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("%0t: mismatch", $time);
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_data_byte = 8'h00;
   logic               req_new_message = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_body_valid;
   logic [7:0]         rsp_body_byte;
   logic               rsp_message_done;
   logic [1:0]         rsp_error_code;
   logic signed [31:0] rsp_original_body_flag;

   decode_tracker tracker;
   logic [7:0]    msg[$];       // bytes of the message being built
   bit            tx_steady;    // send the current message back to back
   bit            rx_hold_req;  // ask the receiver for a long hold-off

   http_chunked_body_decoder #(.SIZE_BITS(SIZE_BITS)) uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_data_byte          (req_data_byte),
      .req_new_message        (req_new_message),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_body_valid         (rsp_body_valid),
      .rsp_body_byte          (rsp_body_byte),
      .rsp_message_done       (rsp_message_done),
      .rsp_error_code         (rsp_error_code),
      .rsp_original_body_flag (rsp_original_body_flag)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---- message building ----
   function automatic logic [7:0] hex_char(int unsigned d);
      if (d < 10) return 8'(d) + CHAR_ZERO;
      return 8'(d - 10) + ($urandom_range(0, 1) ? 8'h41 : 8'h61);
   endfunction

   function automatic logic [7:0] special_byte();
      case ($urandom_range(0, 5))
         0: return CHAR_CR;
         1: return CHAR_LF;
         2: return CHAR_QUOTE;
         3: return CHAR_SEMI;
         4: return CHAR_BSLASH;
         default: return CHAR_ZERO;
      endcase
   endfunction

   function automatic int unsigned cr_run();
      return ($urandom_range(0, 99) < 75) ? 1 : $urandom_range(0, 2);
   endfunction

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
   endtask

   task automatic push_eol(int unsigned crs);
      repeat (crs) msg.push_back(CHAR_CR);
      msg.push_back(CHAR_LF);
   endtask

   // hex size, random case, sometimes with leading zeros
   task automatic push_size(int unsigned n);
      int unsigned nd;
      nd = 1;
      while (nd < 8 && (n >> (4 * nd)) != 0) nd++;
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) msg.push_back(CHAR_ZERO);
      for (int i = nd - 1; i >= 0; i--) msg.push_back(hex_char((n >> (4 * i)) & 15));
   endtask

   task automatic push_token();
      string letters;
      letters = "abxyz-0";
      repeat ($urandom_range(1, 5)) msg.push_back(letters[$urandom_range(0, 6)]);
   endtask

   // quoted string with escapes, semicolons and line feeds inside
   task automatic push_quoted();
      int unsigned r;
      msg.push_back(CHAR_QUOTE);
      repeat ($urandom_range(0, 4)) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            msg.push_back(CHAR_BSLASH);
            msg.push_back(CHAR_QUOTE);
         end else if (r < 25) begin
            msg.push_back(CHAR_LF);
         end else if (r < 35) begin
            msg.push_back(CHAR_SEMI);
         end else begin
            push_token();
         end
      end
      msg.push_back(CHAR_QUOTE);
   endtask

   task automatic push_decimal();
      case ($urandom_range(0, 9))
         0: push_text("2147483647");
         1: push_text("2147483648");
         2: repeat ($urandom_range(10, 13)) msg.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
         default: repeat ($urandom_range(1, 4))
            msg.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      endcase
   endtask

   task automatic build_well_formed();
      int unsigned n;
      // data chunks
      repeat ($urandom_range(0, 3)) begin
         n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
         push_size(n);
         if ($urandom_range(0, 99) < 35) begin
            repeat ($urandom_range(1, 2)) begin
               msg.push_back(CHAR_SEMI);
               push_token();
               if ($urandom_range(0, 1)) begin
                  push_text("=");
                  if ($urandom_range(0, 1)) push_quoted();
                  else push_token();
               end
            end
         end
         push_eol(cr_run());
         repeat (n) msg.push_back(($urandom_range(0, 3) == 0) ? special_byte() : 8'($urandom));
         push_eol(cr_run());
      end
      // last chunk and its extensions
      push_text(($urandom_range(0, 3) == 0) ? "000" : "0");
      case ($urandom_range(0, 8))
         0: ;
         1: begin push_text(";use-original-body="); push_decimal(); end
         2: begin push_text(" \t; use-original-body="); push_decimal(); end
         3: begin push_text(";ab=c;use-original-body="); push_decimal(); end
         4: begin push_text(";use-original-bodx=5;use-original-body="); push_decimal(); end
         5: push_text($urandom_range(0, 1) ? ";use-original-body=;x" : ";use-original-body=-7");
         6: begin
            push_text(";use-original-body=");
            push_decimal();
            push_text(";use-original-body=99");
         end
         7: begin push_text(";q=\"a;b\\\"c\";use-original-body="); push_decimal(); end
         default: push_text("x;use-original-body=1");
      endcase
      push_eol(cr_run());
      // trailer lines, then the empty line
      repeat ($urandom_range(0, 2)) begin
         push_text("X-");
         push_token();
         push_text(": ");
         if ($urandom_range(0, 1)) push_quoted();
         else push_token();
         if ($urandom_range(0, 3) == 0) begin
            msg.push_back(CHAR_CR);
            push_token();
         end
         push_eol(cr_run());
      end
      push_eol(cr_run());
      // stray bytes after the end are dropped by the block
      if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom));
   endtask

   task automatic build_message();
      int unsigned r, cut;
      msg.delete();
      r = $urandom_range(0, 99);
      if (r < 80) begin
         build_well_formed();
         // broken variants: one byte replaced, or cut short
         if (r >= 68 && msg.size() > 1) begin
            cut = $urandom_range(0, msg.size() - 1);
            if ($urandom_range(0, 1)) msg[cut] = 8'($urandom);
            else while (msg.size() > cut + 1) void'(msg.pop_back());
         end
      end else if (r < 90) begin
         // size lines at the edge of the counter
         case ($urandom_range(0, 3))
            0: begin
               push_text("7");
               repeat (15) msg.push_back(hex_char(15));
               if ($urandom_range(0, 1)) msg.push_back(hex_char($urandom_range(0, 15)));
               push_eol(1);
               repeat (3) msg.push_back(8'($urandom));
            end
            1: begin
               msg.push_back(hex_char($urandom_range(8, 15)));
               repeat (15) msg.push_back(hex_char($urandom_range(0, 15)));
            end
            2: begin
               msg.push_back(hex_char($urandom_range(1, 15)));
               repeat (16 + $urandom_range(0, 2)) msg.push_back(hex_char($urandom_range(0, 15)));
            end
            default: begin
               repeat (18) msg.push_back(CHAR_ZERO);
               push_text("1");
               push_eol(1);
               msg.push_back(8'($urandom));
               push_eol(1);
               push_text("0");
               push_eol(1);
               push_eol(1);
            end
         endcase
      end else begin
         // noise
         if ($urandom_range(0, 1)) msg.push_back(hex_char($urandom_range(0, 15)));
         repeat ($urandom_range(3, 15))
            msg.push_back(($urandom_range(0, 2) == 0) ? special_byte() : 8'($urandom));
      end
   endtask

   // ---- driving ----
   task automatic send_item(logic [7:0] c, logic fresh, int unsigned gap);
      bit taken;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_data_byte   = c;
      req_new_message = fresh;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_ready;
      end
      tracker.take_byte(c, fresh);
      @(negedge clock);
   endtask

   task automatic send_message(bit fresh_start);
      int unsigned gap, r;
      for (int i = 0; i < msg.size(); i++) begin
         r = $urandom_range(0, 99);
         if (tx_steady || r < 60) gap = 0;
         else if (r < 97) gap = $urandom_range(1, 3);
         else gap = $urandom_range(10, 40);
         send_item(msg[i], (i == 0) ? fresh_start : ($urandom_range(0, 199) == 0), gap);
      end
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      do @(negedge clock); while (tracker.pending.size() != 0);
   endtask

   // ---- stimulus ----
   initial begin
      int unsigned msg_count;
      tracker = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // two-byte chunk with 00 and FF, then last chunk and empty trailer
      msg.delete();
      push_text("2");
      push_eol(1);
      msg.push_back(8'h00);
      msg.push_back(8'hFF);
      push_eol(1);
      push_text("0");
      push_eol(1);
      push_eol(1);
      send_message(1'b1);
      // no hex digit
      msg.delete();
      push_text("x");
      send_message(1'b1);
      // bare LF after the size, then data where the chunk end belongs
      msg.delete();
      push_text("1");
      push_eol(0);
      push_text("AB");
      send_message(1'b1);
      // LF inside a quoted extension does not end the line
      msg.delete();
      push_text("0\"");
      push_eol(0);
      push_text("\"");
      push_eol(0);
      push_eol(1);
      send_message(1'b1);
      wait_drained();

      // random messages, mostly well formed
      msg_count = 0;
      while (tracker.taken_items < ITEM_TARGET) begin
         build_message();
         tx_steady = ($urandom_range(0, 3) == 0);
         if (msg_count == 6) rx_hold_req = 1'b1;
         // keep offering items while the receiver holds off
         if (msg_count >= 6 && msg_count <= 9) tx_steady = 1'b1;
         if (msg_count == 14) wait_drained();
         send_message($urandom_range(0, 19) != 0);
         msg_count++;
      end
      wait_drained();
      repeat (20) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending.size() == 0) begin
         $display("http_chunked_body_decoder verification clean");
      end else begin
         $display("http_chunked_body_decoder verification failed");
      end
      $finish;
   end

   // ---- receiver: random stalls, free-running stretches, one long hold ----
   initial begin
      int               stall_left, eager_left, hold_left, r;
      bit               hold_used;
      decoded_item_type got;
      rsp_ready  = 1'b0;
      stall_left = 0;
      eager_left = 0;
      hold_left  = 0;
      hold_used  = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (rx_hold_req && !hold_used) begin
            hold_left = RX_HOLD_CYCLES;
            hold_used = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (eager_left > 0) begin
            rsp_ready = 1'b1;
            eager_left--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 20) stall_left = $urandom_range(1, 3);
            else if (r < 23) stall_left = $urandom_range(15, 50);
            else if (r < 25) eager_left = $urandom_range(50, 150);
         end
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready) begin
            got = {rsp_body_valid, rsp_body_byte, rsp_message_done, rsp_error_code,
                   rsp_original_body_flag};
            tracker.compare_result(got);
         end
      end
   end

   // run limit
   initial begin
      #4_000_000;
      $display("http_chunked_body_decoder verification failed");
      $finish;
   end

endmodule
